// File: rtl/arc_pkg.sv
// Package for the acceleration ramp calculator: widths, status codes and
// register indexes. No dependencies.
`timescale 1ns / 1ps
package arc_pkg;

  localparam int SPEED_BITS_DEF = 15;
  localparam int COURSE_W       = 16;
  localparam int DIST_W         = 31;
  localparam int STATUS_W       = 2;
  localparam int APB_DW         = 32;
  localparam int APB_AW         = 4;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_ORDER    = 2'd1,
    ST_ACC_ZERO = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_MIN = 2'd0,
    REG_MAX = 2'd1,
    REG_ACC = 2'd2
  } reg_idx_e;

endpackage

// File: rtl/arc_if.sv
// Valid/ready channel interfaces for the ramp calculator requests and results.
// Depends on arc_pkg.
`timescale 1ns / 1ps
interface arc_in_if import arc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [COURSE_W-1:0] course;

  modport source (output valid, output course, input ready);
  modport sink   (input valid, input course, output ready);
endinterface

interface arc_out_if import arc_pkg::*; #(
  parameter int SB = SPEED_BITS_DEF
) ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SB-1:0]       ramp_time;
  logic [DIST_W-1:0]   ramp_distance;

  modport source (output valid, output status, output ramp_time, output ramp_distance,
                  input ready);
  modport sink   (input valid, input status, input ramp_time, input ramp_distance,
                  output ready);
endinterface

// File: rtl/arc_isqrt.sv
// Pipelined integer square root, one root bit per register stage.
// Depends on arc_pkg.
`timescale 1ns / 1ps
module arc_isqrt import arc_pkg::*; #(
  parameter int RB = SPEED_BITS_DEF + 2
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [2*RB-1:0] rad_i,
  output logic [RB-1:0] root_o
);

  logic [2*RB-1:0] rad_q  [RB];
  logic [RB+1:0]   rem_q  [RB];
  logic [RB-1:0]   root_q [RB];

  for (genvar k = 0; k < RB; k++) begin : g_stage
    logic [2*RB-1:0] rad_in;
    logic [RB+1:0]   rem_in;
    logic [RB-1:0]   root_in;
    logic [RB+1:0]   rem_s;
    logic [RB+1:0]   trial;

    if (k == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // bring down the next bit pair and try root*4+1
    assign rem_s = {rem_in[RB-1:0], rad_in[2*RB-1 -: 2]};
    assign trial = {root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k] <= rad_in << 2;
        if (rem_s >= trial) begin
          rem_q[k]  <= rem_s - trial;
          root_q[k] <= {root_in[RB-2:0], 1'b1};
        end else begin
          rem_q[k]  <= rem_s;
          root_q[k] <= {root_in[RB-2:0], 1'b0};
        end
      end
    end
  end

  assign root_o = root_q[RB-1];

endmodule

// File: rtl/arc_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on arc_pkg.
`timescale 1ns / 1ps
module arc_div import arc_pkg::*; #(
  parameter int NB = SPEED_BITS_DEF + 2,
  parameter int DB = SPEED_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NB-1:0] num_i,
  input  logic [DB-1:0] den_i,
  output logic [NB-1:0] quo_o
);

  logic [NB-1:0] num_q [NB];
  logic [DB-1:0] rem_q [NB];
  logic [NB-1:0] quo_q [NB];

  for (genvar k = 0; k < NB; k++) begin : g_stage
    logic [NB-1:0] num_in;
    logic [DB-1:0] rem_in;
    logic [NB-1:0] quo_in;
    logic [DB:0]   rem_s;

    if (k == 0) begin : g_first
      assign num_in = num_i;
      assign rem_in = '0;
      assign quo_in = '0;
    end else begin : g_next
      assign num_in = num_q[k-1];
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign rem_s = {rem_in, num_in[NB-1]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k] <= num_in << 1;
        if (rem_s >= {1'b0, den_i}) begin
          rem_q[k] <= DB'(rem_s - {1'b0, den_i});
          quo_q[k] <= {quo_in[NB-2:0], 1'b1};
        end else begin
          rem_q[k] <= rem_s[DB-1:0];
          quo_q[k] <= {quo_in[NB-2:0], 1'b0};
        end
      end
    end
  end

  assign quo_o = quo_q[NB-1];

endmodule

// File: rtl/accel_ramp_calculator.sv
// Top level of the trapezoidal acceleration ramp calculator.
// Depends on arc_pkg, arc_if, arc_isqrt and arc_div.
//
// Usage:
//   Write min_speed (0x0), max_speed (0x4) and acceleration (0x8) over the
//   APB port while no request is in flight. Each request on in_i carries a
//   move length (course); each yields exactly one result on out_o with a
//   status, the ramp time in whole seconds and the ramp distance in steps.
//   The square root and the divider each take one register stage per result
//   bit, and the pipeline accepts one request every cycle while the result
//   register is free or being taken by the receiver.
//   Reset clears all valid bits and sets min_speed = 0, max_speed = 0,
//   acceleration = 1. When the receiver stalls, the result register holds
//   and the whole pipeline freezes, so in_i.ready drops in the same cycle;
//   nothing is dropped or repeated.
`timescale 1ns / 1ps
module accel_ramp_calculator import arc_pkg::*; #(
  parameter int SPEED_BITS = SPEED_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  arc_in_if.sink            in_i,
  arc_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int S  = SPEED_BITS;
  localparam int RB = ((S > COURSE_W) ? S : COURSE_W) + 1;
  localparam int DW = (3*S + 1 > DIST_W) ? 3*S + 1 : DIST_W;
  localparam int V  = 2*RB + 6;

  logic [S-1:0] min_q, max_q, acc_q;
  reg_idx_e     widx;

  assign widx   = reg_idx_e'(paddr[3:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= '0;
      max_q <= '0;
      acc_q <= S'(1);
    end else if (psel && penable && pwrite) begin
      case (widx)
        REG_MIN: min_q <= pwdata[S-1:0];
        REG_MAX: max_q <= pwdata[S-1:0];
        REG_ACC: acc_q <= pwdata[S-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_MIN: prdata = APB_DW'(min_q);
      REG_MAX: prdata = APB_DW'(max_q);
      REG_ACC: prdata = APB_DW'(acc_q);
      default: prdata = '0;
    endcase
  end

  // global advance: move everything when the result register is free or taken
  logic         adv;
  logic [V-1:0] vld_q;
  logic         out_vld_q;

  assign adv        = !out_vld_q || out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[V-2:0], in_i.valid};
      out_vld_q <= vld_q[V-1];
    end
  end

  // radicand: min_speed^2 + acceleration*course
  logic [S+COURSE_W-1:0] ac_q;
  logic [2*S-1:0]        sq_q;
  logic [2*RB-1:0]       rad_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ac_q  <= acc_q * in_i.course;
      sq_q  <= min_q * min_q;
      rad_q <= (2*RB)'(ac_q) + (2*RB)'(sq_q);
    end
  end

  logic [RB-1:0] root;

  arc_isqrt #(.RB(RB)) u_isqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (rad_q),
    .root_o (root)
  );

  logic [RB-1:0] vmin_x;
  logic [RB-1:0] numl_q, numt_q;

  assign vmin_x = RB'(min_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      numl_q <= (root > vmin_x) ? root - vmin_x : '0;
      numt_q <= RB'(max_q - min_q);
    end
  end

  logic [RB-1:0] tlen, ttop;

  arc_div #(.NB(RB), .DB(S)) u_div_len (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (numl_q),
    .den_i (acc_q),
    .quo_o (tlen)
  );

  arc_div #(.NB(RB), .DB(S)) u_div_top (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (numt_q),
    .den_i (acc_q),
    .quo_o (ttop)
  );

  logic [S-1:0]   t_q, t2_q, t3_q;
  logic [2*S-1:0] p1_q, vt_q, vt2_q;
  logic [3*S-1:0] p2_q;
  logic [DW-1:0]  dist_sum;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t_q   <= (tlen < ttop) ? tlen[S-1:0] : ttop[S-1:0];
      p1_q  <= acc_q * t_q;
      vt_q  <= min_q * t_q;
      t2_q  <= t_q;
      p2_q  <= p1_q * t2_q;
      vt2_q <= vt_q;
      t3_q  <= t2_q;
    end
  end

  assign dist_sum = (DW'(p2_q) >> 1) + DW'(vt2_q);

  // errors depend on configuration only, which the user must hold while requests are in flight (not enforced here)
  status_e            st;
  status_e            st_q;
  logic [S-1:0]       time_q;
  logic [DIST_W-1:0]  dist_q;

  always_comb begin
    if (acc_q == '0) begin
      st = ST_ACC_ZERO;
    end else if (min_q > max_q) begin
      st = ST_ORDER;
    end else begin
      st = ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q   <= st;
      time_q <= (st == ST_OK) ? t3_q : '0;
      dist_q <= (st == ST_OK) ? dist_sum[DIST_W-1:0] : '0;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.status        = st_q;
  assign out_o.ramp_time     = time_q;
  assign out_o.ramp_distance = dist_q;

endmodule

// File: rtl/arc_checker.sv
// Port-level checks for the ramp calculator, bound to the top level.
// Depends on arc_pkg and accel_ramp_calculator.
`timescale 1ns / 1ps
module arc_checker import arc_pkg::*; #(
  parameter int SB = SPEED_BITS_DEF
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] status,
  input logic [SB-1:0]       ramp_time,
  input logic [DIST_W-1:0]   ramp_distance
);

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status != ST_OK |-> ramp_time == '0 && ramp_distance == '0)
    else $error("error result carries nonzero time or distance");

  a_no_time_no_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status == ST_OK && ramp_time == '0 |-> ramp_distance == '0)
    else $error("zero ramp time with nonzero distance");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("request refused while result register empty");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(ramp_distance) && $stable(ramp_time))
    else $error("stalled result changed");

endmodule

bind accel_ramp_calculator arc_checker #(.SB(SPEED_BITS)) u_arc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready      (in_i.ready),
  .out_valid     (out_o.valid),
  .out_ready     (out_o.ready),
  .status        (out_o.status),
  .ramp_time     (out_o.ramp_time),
  .ramp_distance (out_o.ramp_distance)
);
